### hdl/rti_pkg.sv
// shared types, constants and saturating arithmetic helpers for the ray/triangle test
package rti_pkg;

  // default fraction bits of the Q format and fraction bits of the unit normal
  localparam int FracBitsDef = 16;
  localparam int NormBits    = 30;

  // square root unit widths
  localparam int RadW  = 64;
  localparam int RootW = 32;

  // saturation bounds of a 32-bit signed result
  localparam logic signed [63:0] Max32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Min32 = -64'sh0000_0000_8000_0000;

  typedef logic [2:0][31:0] vec3_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_MISS    = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_INSIDE  = 2'd2
  } status_e;

  // vertices and ray carried along with a test item
  typedef struct packed {
    vec3_t a;
    vec3_t b;
    vec3_t c;
    vec3_t o;
    vec3_t d;
  } geo_t;

  // sideband through the square root unit
  typedef struct packed {
    geo_t  geo;
    vec3_t n;
  } core_t;

  // sideband through the normal dividers
  typedef struct packed {
    geo_t        geo;
    vec3_t       n;
    logic [31:0] t;
    logic        miss;
  } nrm_t;

  // clamp a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > Max32) begin
      r = 32'h7FFF_FFFF;
    end else if (v < Min32) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // saturating difference of two signed 32-bit values
  function automatic logic [31:0] sub_sat32(input logic [31:0] x, input logic [31:0] y);
    logic signed [63:0] dd;
    dd = $signed({{32{x[31]}}, x}) - $signed({{32{y[31]}}, y});
    return sat32(dd);
  endfunction

  // exact signed 32 by 32 product
  function automatic logic signed [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [63:0] r;
    xs = x;
    ys = y;
    r  = xs * ys;
    return r;
  endfunction

endpackage

### hdl/rti_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module rti_div #(
  parameter int NW = 49,
  parameter int DW = 32,
  parameter int QB = 31,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [QB-1:0] quo_o,
  output logic          ovf_o,
  output logic [PW-1:0] pay_o
);

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic [CW-1:0] rem_q [QB+1];
  logic [CW-1:0] rem_d [QB+1];
  logic [DW-1:0] dsr_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [QB-1:0] quo_d [QB+1];
  logic          ovf_q [QB+1];
  logic          vld_q [QB+1];
  logic [PW-1:0] pay_q [QB+1];

  // one trial subtraction per stage
  always_comb begin
    logic [CW-1:0] sub;
    rem_d[0] = CW'(num_i);
    quo_d[0] = '0;
    for (int k = 1; k <= QB; k++) begin
      sub = CW'(dsr_q[k-1]) << (QB - k);
      if (rem_q[k-1] >= sub) begin
        rem_d[k] = rem_q[k-1] - sub;
        quo_d[k] = quo_q[k-1] | (QB'(1) << (QB - k));
      end else begin
        rem_d[k] = rem_q[k-1];
        quo_d[k] = quo_q[k-1];
      end
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= QB; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      dsr_q[0] <= den_i;
      quo_q[0] <= quo_d[0];
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << QB);
      pay_q[0] <= pay_i;
      for (int k = 1; k <= QB; k++) begin
        rem_q[k] <= rem_d[k];
        dsr_q[k] <= dsr_q[k-1];
        quo_q[k] <= quo_d[k];
        ovf_q[k] <= ovf_q[k-1];
        pay_q[k] <= pay_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[QB];
  assign quo_o   = quo_q[QB];
  assign ovf_o   = ovf_q[QB];
  assign pay_o   = pay_q[QB];

endmodule

### hdl/rti_isqrt.sv
// pipelined integer square root, one result bit per stage
module rti_isqrt
  import rti_pkg::*;
#(
  parameter int PW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [PW-1:0]    pay_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [PW-1:0]    pay_o
);

  localparam int NS = RootW;

  logic [RadW-1:0] val_q [NS];
  logic [RadW-1:0] val_d [NS];
  logic [RadW-1:0] rt_q  [NS];
  logic [RadW-1:0] rt_d  [NS];
  logic            vld_q [NS];
  logic [PW-1:0]   pay_q [NS];

  // one bit pair per stage
  always_comb begin
    logic [RadW-1:0] vi;
    logic [RadW-1:0] ri;
    logic [RadW-1:0] bt;
    for (int k = 0; k < NS; k++) begin
      vi = (k == 0) ? rad_i : val_q[(k == 0) ? 0 : k - 1];
      ri = (k == 0) ? '0 : rt_q[(k == 0) ? 0 : k - 1];
      bt = RadW'(1) << (RadW - 2 - 2 * k);
      if (vi >= ri + bt) begin
        val_d[k] = vi - (ri + bt);
        rt_d[k]  = (ri >> 1) + bt;
      end else begin
        val_d[k] = vi;
        rt_d[k]  = ri >> 1;
      end
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= pay_i;
      for (int k = 1; k < NS; k++) pay_q[k] <= pay_q[k-1];
      for (int k = 0; k < NS; k++) begin
        val_q[k] <= val_d[k];
        rt_q[k]  <= rt_d[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = rt_q[NS-1][RootW-1:0];
  assign pay_o   = pay_q[NS-1];

endmodule

### hdl/ray_triangle_intersect.sv
// top level of the pipelined ray/triangle intersection test
// A load item (tuser 0) stores the ray origin (a) and direction (b) and gives no result; a
// test item (tuser 1) gives one result item. One item is taken every cycle unless the output
// holds: the path is a fixed pipeline of 6 front stages (edges, cross product, dot products),
// a 32-stage divider for the plane distance beside a 32-stage square root for the normal
// length, one stage for the ray parameter, three 32-stage dividers for the unit normal,
// 6 stages for hit point and edge tests, and the output register. The whole pipeline holds
// while a result waits on m_axis_tready; tests see the ray of the last load taken before them.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,   // parallel_threshold
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, vec_c_x, vec_c_y, vec_c_z
  input  logic [287:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z
  output logic [191:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // hit_status
);

  localparam int TdivNW = 33 + FracBits;
  localparam int NdivNW = 32 + NormBits;
  localparam int QuoW   = 31;

  logic        en;
  logic        accept;
  logic [30:0] thr_q;
  vec3_t       orig_q, dir_q;
  vec3_t       in_a, in_b, in_c;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign in_a[i] = s_axis_tdata[32*i +: 32];
    assign in_b[i] = s_axis_tdata[96 + 32*i +: 32];
    assign in_c[i] = s_axis_tdata[192 + 32*i +: 32];
  end

  // threshold register and stored ray
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 31'd1;
      orig_q <= '0;
      dir_q  <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (accept && op_e'(s_axis_tuser) == OP_LOAD) begin
        orig_q <= in_a;
        dir_q  <= in_b;
      end
    end
  end

  // ---------------- front stages ----------------
  logic               va_q, vb_q, vc_q, vd_q, ve_q, vf_q;
  geo_t               ga_q, gb_q, gc_q, gd_q, ge_q, gf_q;
  vec3_t              e1_q, e2_q;
  logic signed [63:0] cpp_q [3];
  logic signed [63:0] cpn_q [3];
  vec3_t              nc_q, nd_q, ne_q, nf_q;
  logic signed [63:0] pnd_q [3];
  logic signed [63:0] pna_q [3];
  logic signed [63:0] pno_q [3];
  logic signed [63:0] psq_q [3];
  logic [31:0]        den_q, nda_q, ndo_q;
  logic [63:0]        sumsq_e_q, sumsq_f_q;
  logic [32:0]        absnum_q;
  logic [31:0]        absden_q;
  logic               negt_q, miss0_q;
  logic signed [32:0] num_w;
  logic [31:0]        den_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      va_q <= accept && op_e'(s_axis_tuser) == OP_TEST;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  assign num_w = $signed({nda_q[31], nda_q}) - $signed({ndo_q[31], ndo_q});
  assign den_w = den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // edge vectors
      ga_q <= '{a: in_a, b: in_b, c: in_c, o: orig_q, d: dir_q};
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= sub_sat32(in_b[i], in_a[i]);
        e2_q[i] <= sub_sat32(in_c[i], in_a[i]);
      end
      // cross product terms
      gb_q <= ga_q;
      for (int i = 0; i < 3; i++) begin
        cpp_q[i] <= mul32(e1_q[(i+1)%3], e2_q[(i+2)%3]);
        cpn_q[i] <= mul32(e1_q[(i+2)%3], e2_q[(i+1)%3]);
      end
      // plane normal
      gc_q <= gb_q;
      for (int i = 0; i < 3; i++) begin
        nc_q[i] <= sat32((cpp_q[i] >>> FracBits) - (cpn_q[i] >>> FracBits));
      end
      // dot product terms and squares
      gd_q <= gc_q;
      nd_q <= nc_q;
      for (int i = 0; i < 3; i++) begin
        pnd_q[i] <= mul32(nc_q[i], gc_q.d[i]);
        pna_q[i] <= mul32(nc_q[i], gc_q.a[i]);
        pno_q[i] <= mul32(nc_q[i], gc_q.o[i]);
        psq_q[i] <= mul32(nc_q[i], nc_q[i]);
      end
      // dot product sums
      ge_q      <= gd_q;
      ne_q      <= nd_q;
      den_q     <= sat32((pnd_q[0] >>> FracBits) + (pnd_q[1] >>> FracBits)
                         + (pnd_q[2] >>> FracBits));
      nda_q     <= sat32((pna_q[0] >>> FracBits) + (pna_q[1] >>> FracBits)
                         + (pna_q[2] >>> FracBits));
      ndo_q     <= sat32((pno_q[0] >>> FracBits) + (pno_q[1] >>> FracBits)
                         + (pno_q[2] >>> FracBits));
      sumsq_e_q <= 64'(psq_q[0]) + 64'(psq_q[1]) + 64'(psq_q[2]);
      // numerator, magnitudes and parallel check
      gf_q      <= ge_q;
      nf_q      <= ne_q;
      sumsq_f_q <= sumsq_e_q;
      absnum_q  <= num_w[32] ? 33'(-num_w) : 33'(num_w);
      absden_q  <= den_w[31] ? 32'(-den_w) : den_w;
      negt_q    <= num_w[32] ^ den_w[31];
      miss0_q   <= (den_w == '0) ||
                   ((den_w[31] ? 32'(-den_w) : den_w) < {1'b0, thr_q});
    end
  end

  // ---------------- plane distance divider and normal length ----------------
  logic            tdv, sqv;
  logic [QuoW-1:0] tq;
  logic            tovf;
  logic [1:0]      tpay;
  logic [RootW-1:0] mag;
  core_t           core_in, core_out;

  assign core_in = '{geo: gf_q, n: nf_q};

  rti_div #(
    .NW(TdivNW),
    .DW(32),
    .QB(QuoW),
    .PW(2)
  ) u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vf_q),
    .num_i  ({absnum_q, {FracBits{1'b0}}}),
    .den_i  (absden_q),
    .pay_i  ({negt_q, miss0_q}),
    .valid_o(tdv),
    .quo_o  (tq),
    .ovf_o  (tovf),
    .pay_o  (tpay)
  );

  rti_isqrt #(
    .PW($bits(core_t))
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vf_q),
    .rad_i  (sumsq_f_q),
    .pay_i  (core_in),
    .valid_o(sqv),
    .root_o (mag),
    .pay_o  (core_out)
  );

  // ray parameter, sign test and saturation
  logic             vg_q;
  nrm_t             ng_q;
  logic [RootW-1:0] mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en) begin
      vg_q <= tdv && sqv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ng_q.geo  <= core_out.geo;
      ng_q.n    <= core_out.n;
      ng_q.t    <= tovf ? 32'h7FFF_FFFF : {1'b0, tq};
      ng_q.miss <= tpay[0] || (tpay[1] && (tovf || tq != '0));
      mag_q     <= mag;
    end
  end

  // ---------------- unit normal dividers ----------------
  logic            nv [3];
  logic [QuoW-1:0] nq [3];
  logic            novf [3];
  logic            nsg [3];
  nrm_t            nh;

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    logic [31:0] nmag;
    assign nmag = ng_q.n[i][31] ? 32'(-ng_q.n[i]) : ng_q.n[i];
    if (i == 0) begin : g_lead
      rti_div #(
        .NW(NdivNW),
        .DW(RootW),
        .QB(QuoW),
        .PW($bits(nrm_t) + 1)
      ) u_ndiv (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .valid_i(vg_q),
        .num_i  ({nmag, {NormBits{1'b0}}}),
        .den_i  (mag_q),
        .pay_i  ({ng_q, ng_q.n[i][31]}),
        .valid_o(nv[i]),
        .quo_o  (nq[i]),
        .ovf_o  (novf[i]),
        .pay_o  ({nh, nsg[i]})
      );
    end else begin : g_side
      rti_div #(
        .NW(NdivNW),
        .DW(RootW),
        .QB(QuoW),
        .PW(1)
      ) u_ndiv (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .valid_i(vg_q),
        .num_i  ({nmag, {NormBits{1'b0}}}),
        .den_i  (mag_q),
        .pay_i  (ng_q.n[i][31]),
        .valid_o(nv[i]),
        .quo_o  (nq[i]),
        .ovf_o  (novf[i]),
        .pay_o  (nsg[i])
      );
    end
  end

  // ---------------- hit point and edge tests ----------------
  logic               vh_q, vi_q, vj_q, vk_q, vl_q, vm_q;
  nrm_t               nh_q, ni_q;
  vec3_t              unh_q, uni_q, unj_q, unk_q, unl_q, unm_q;
  vec3_t              nj_q, nk_q, nl_q;
  logic               mj_q, mk_q, ml_q, mm_q;
  logic signed [63:0] tp_q [3];
  vec3_t              pi_q, pj_q, pk_q, pl_q, pm_q;
  vec3_t              ee_q [3];
  vec3_t              vp_q [3];
  logic signed [63:0] kp_q [3][3];
  logic signed [63:0] kn_q [3][3];
  vec3_t              cr_q [3];
  logic signed [63:0] dp_q [3][3];
  vec3_t              unw;
  vec3_t              vert [3];

  for (genvar i = 0; i < 3; i++) begin : g_unit
    logic [31:0] mq;
    assign mq     = novf[i] ? 32'h4000_0000 : {1'b0, nq[i]};
    assign unw[i] = nsg[i] ? 32'(-mq) : mq;
  end

  assign vert[0] = ni_q.geo.a;
  assign vert[1] = ni_q.geo.b;
  assign vert[2] = ni_q.geo.c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
      vk_q <= 1'b0;
      vl_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en) begin
      vh_q <= nv[0] && nv[1] && nv[2];
      vi_q <= vh_q;
      vj_q <= vi_q;
      vk_q <= vj_q;
      vl_q <= vk_q;
      vm_q <= vl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // t times direction
      nh_q  <= nh;
      unh_q <= unw;
      for (int i = 0; i < 3; i++) tp_q[i] <= mul32(nh.t, nh.geo.d[i]);
      // hit point
      ni_q  <= nh_q;
      uni_q <= unh_q;
      for (int i = 0; i < 3; i++) begin
        pi_q[i] <= sat32($signed({{32{nh_q.geo.o[i][31]}}, nh_q.geo.o[i]})
                         + (tp_q[i] >>> FracBits));
      end
      // edge and point vectors
      nj_q  <= ni_q.n;
      mj_q  <= ni_q.miss;
      unj_q <= uni_q;
      pj_q  <= pi_q;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          ee_q[k][i] <= sub_sat32(vert[(k+1)%3][i], vert[k][i]);
          vp_q[k][i] <= sub_sat32(pi_q[i], vert[k][i]);
        end
      end
      // edge cross product terms
      nk_q  <= nj_q;
      mk_q  <= mj_q;
      unk_q <= unj_q;
      pk_q  <= pj_q;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          kp_q[k][i] <= mul32(ee_q[k][(i+1)%3], vp_q[k][(i+2)%3]);
          kn_q[k][i] <= mul32(ee_q[k][(i+2)%3], vp_q[k][(i+1)%3]);
        end
      end
      // edge cross products
      nl_q  <= nk_q;
      ml_q  <= mk_q;
      unl_q <= unk_q;
      pl_q  <= pk_q;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          cr_q[k][i] <= sat32((kp_q[k][i] >>> FracBits) - (kn_q[k][i] >>> FracBits));
        end
      end
      // dot with the normal
      mm_q  <= ml_q;
      unm_q <= unl_q;
      pm_q  <= pl_q;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) dp_q[k][i] <= mul32(nl_q[i], cr_q[k][i]);
      end
    end
  end

  // ---------------- output register ----------------
  logic         ov_q;
  status_e      st_q;
  logic [191:0] od_q;
  logic [2:0]   edge_ok;
  status_e      st_d;

  always_comb begin
    logic signed [63:0] s;
    for (int k = 0; k < 3; k++) begin
      s = (dp_q[k][0] >>> FracBits) + (dp_q[k][1] >>> FracBits) + (dp_q[k][2] >>> FracBits);
      edge_ok[k] = !s[63];
    end
    if (mm_q) begin
      st_d = ST_MISS;
    end else if (&edge_ok) begin
      st_d = ST_INSIDE;
    end else begin
      st_d = ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
      od_q <= mm_q ? '0 : {unm_q, pm_q};
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = st_q;
  assign m_axis_tdata  = od_q;

endmodule
